// ===== rtl/core/scfd_pkg.sv =====
// ----------------------------------------------------------------------------
// scfd_pkg - shared types and constants of the serial-to-CAN deframer
// Marker bytes, field widths and the command word that travels from the
// byte classifier to the frame builder.
// ----------------------------------------------------------------------------
package scfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int ID_W      = 11;
    localparam int LEN_W     = 4;
    localparam int NUM_BYTES = 8;
    localparam int IDX_W     = $clog2(NUM_BYTES);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] START_MARK  = 8'hFD;
    localparam logic [BYTE_W-1:0] END_MARK    = 8'hBF;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD = 4'd8;

    typedef logic [BYTE_W-1:0] t_byte;

    // Frame part a received byte stands for
    typedef enum logic [2:0] {
        OP_START,
        OP_HEADER,
        OP_ID_LOW,
        OP_DATA,
        OP_END
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [LEN_W-1:0] idx;   // payload byte number for OP_DATA
        t_byte            data;
    } t_cmd;

    // Push request from the producer to the queue
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage

// ===== rtl/core/scfd_byte_if.sv =====
// ----------------------------------------------------------------------------
// scfd_byte_if - serial byte channel
// Valid/ready channel carrying one received byte per transfer.
// ----------------------------------------------------------------------------
interface scfd_byte_if;
    import scfd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/scfd_msg_if.sv =====
// ----------------------------------------------------------------------------
// scfd_msg_if - CAN message channel
// Valid/ready channel carrying one standard CAN message per transfer.
// ----------------------------------------------------------------------------
interface scfd_msg_if;
    import scfd_pkg::*;

    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  can_id;
    logic [LEN_W-1:0] payload_length;
    t_byte            payload_b0;
    t_byte            payload_b1;
    t_byte            payload_b2;
    t_byte            payload_b3;
    t_byte            payload_b4;
    t_byte            payload_b5;
    t_byte            payload_b6;
    t_byte            payload_b7;

    modport source (
        output valid, output can_id, output payload_length,
        output payload_b0, output payload_b1, output payload_b2, output payload_b3,
        output payload_b4, output payload_b5, output payload_b6, output payload_b7,
        input  ready
    );
    modport sink (
        input  valid, input can_id, input payload_length,
        input  payload_b0, input payload_b1, input payload_b2, input payload_b3,
        input  payload_b4, input payload_b5, input payload_b6, input payload_b7,
        output ready
    );
endinterface

// ===== rtl/core/scfd_front.sv =====
// ----------------------------------------------------------------------------
// scfd_front - byte classifier
// Tracks the frame phase and turns each frame byte into a command.
// ----------------------------------------------------------------------------
module scfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scfd_byte_if.sink     i_rx,
    input  logic          i_q_full,
    output scfd_pkg::t_push o_push
);
    import scfd_pkg::*;

    localparam logic [2:0] PH_WAIT_START = 3'd0;
    localparam logic [2:0] PH_HEADER     = 3'd1;
    localparam logic [2:0] PH_ID_LOW     = 3'd2;
    localparam logic [2:0] PH_DATA       = 3'd3;
    localparam logic [2:0] PH_END        = 3'd4;

    logic [2:0]       r_phase, n_phase;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] cnt_inc;
    logic             accept;

    assign i_rx.ready = ~i_q_full;
    assign accept     = i_rx.valid & i_rx.ready;
    assign cnt_inc    = r_cnt + 1'b1;

    always_comb begin
        n_phase         = r_phase;
        n_cnt           = r_cnt;
        n_len           = r_len;
        o_push.valid    = 1'b0;
        o_push.cmd.op   = OP_START;
        o_push.cmd.idx  = r_cnt;
        o_push.cmd.data = i_rx.rx_byte;
        unique case (r_phase)
            PH_HEADER: begin
                o_push.cmd.op = OP_HEADER;
                o_push.valid  = accept;
                n_len         = i_rx.rx_byte[BYTE_W-1 -: LEN_W];
                n_phase       = PH_ID_LOW;
            end
            PH_ID_LOW: begin
                o_push.cmd.op = OP_ID_LOW;
                o_push.valid  = accept;
                n_cnt         = '0;
                n_phase       = (r_len == '0) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
                o_push.cmd.op = OP_DATA;
                o_push.valid  = accept;
                n_cnt         = cnt_inc;
                if ((cnt_inc == '0) || (cnt_inc >= r_len)) begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                o_push.cmd.op = OP_END;
                o_push.valid  = accept;
                n_phase       = PH_WAIT_START;
            end
            default: begin
                // Ignore everything but the start marker; unused codes land here too
                o_push.cmd.op = OP_START;
                o_push.valid  = accept & (i_rx.rx_byte == START_MARK);
                n_phase       = (i_rx.rx_byte == START_MARK) ? PH_HEADER : PH_WAIT_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_START;
            r_cnt   <= '0;
            r_len   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
        end
    end

endmodule

// ===== rtl/core/scfd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// scfd_cmd_fifo - command queue
// Short queue that decouples the byte classifier from the frame builder.
// ----------------------------------------------------------------------------
module scfd_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scfd_pkg::t_push  i_push,
    output logic             o_full,
    output logic             o_valid,
    output scfd_pkg::t_cmd   o_cmd,
    input  logic             i_pop
);
    import scfd_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push.valid & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/scfd_back.sv =====
// ----------------------------------------------------------------------------
// scfd_back - frame builder
// Executes queued commands, assembles the frame and registers the message.
// ----------------------------------------------------------------------------
module scfd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  scfd_pkg::t_cmd i_cmd,
    output logic           o_pop,
    scfd_msg_if.source     o_msg
);
    import scfd_pkg::*;

    t_byte            r_store [NUM_BYTES];
    logic [ID_W-1:0]  r_id;
    logic [LEN_W-1:0] r_len;

    logic             r_out_valid;
    logic [ID_W-1:0]  r_out_id;
    logic [LEN_W-1:0] r_out_len;
    t_byte            r_out_b [NUM_BYTES];

    logic out_free;
    logic frame_ok;

    assign out_free = ~r_out_valid | o_msg.ready;
    // Hold an end command until the output register can take the message
    assign o_pop    = i_valid & ((i_cmd.op != OP_END) | out_free);
    assign frame_ok = (i_cmd.data == END_MARK) && (r_len <= MAX_PAYLOAD);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (i_cmd.op)
                OP_START: begin
                    for (int k = 0; k < NUM_BYTES; k++) begin
                        r_store[k] <= '0;
                    end
                end
                OP_HEADER: begin
                    r_len <= i_cmd.data[BYTE_W-1 -: LEN_W];
                    r_id  <= {i_cmd.data[ID_W-BYTE_W-1:0], r_id[BYTE_W-1:0]};
                end
                OP_ID_LOW: begin
                    r_id <= {r_id[ID_W-1:BYTE_W], i_cmd.data};
                end
                OP_DATA: begin
                    if (i_cmd.idx < LEN_W'(NUM_BYTES)) begin
                        r_store[i_cmd.idx[IDX_W-1:0]] <= i_cmd.data;
                    end
                end
                OP_END: begin
                    r_out_id  <= r_id;
                    r_out_len <= r_len;
                    for (int k = 0; k < NUM_BYTES; k++) begin
                        r_out_b[k] <= (LEN_W'(k) < r_len) ? r_store[k] : '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && (i_cmd.op == OP_END) && frame_ok) begin
            r_out_valid <= 1'b1;
        end else if (o_msg.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_msg.valid          = r_out_valid;
    assign o_msg.can_id         = r_out_id;
    assign o_msg.payload_length = r_out_len;
    assign o_msg.payload_b0     = r_out_b[0];
    assign o_msg.payload_b1     = r_out_b[1];
    assign o_msg.payload_b2     = r_out_b[2];
    assign o_msg.payload_b3     = r_out_b[3];
    assign o_msg.payload_b4     = r_out_b[4];
    assign o_msg.payload_b5     = r_out_b[5];
    assign o_msg.payload_b6     = r_out_b[6];
    assign o_msg.payload_b7     = r_out_b[7];

endmodule

// ===== rtl/core/serial_to_can_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// serial_to_can_frame_deframer - serial byte stream to CAN message deframer
// Recognizes 0xFD / header / id-low / payload / 0xBF frames and emits one
// standard CAN message for each frame whose end marker and length are good.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  i_rx      in    valid/ready    rx_byte[7:0]
//  o_msg     out   valid/ready    can_id[10:0], payload_length[3:0],
//                                 payload_b0..payload_b7[7:0]
//
//  One byte per cycle is taken while the queue is not full; the classifier
//  decides the frame phase in the same cycle as the transfer.
//  After its end marker is taken, a message passes through a queue entry
//  and then the output register before it appears on o_msg, when nothing
//  older waits in the queue.
//  Reset is synchronous on i_rst_n: it clears the phase, the queue and the
//  output valid; payload storage is cleared by each start marker.
//  When o_msg stalls, the end command waits at the queue head; i_rx keeps
//  taking bytes until the two-entry queue fills.
// ----------------------------------------------------------------------------
module serial_to_can_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scfd_byte_if.sink  i_rx,
    scfd_msg_if.source o_msg
);
    import scfd_pkg::*;

    t_push push;
    t_cmd  q_cmd;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    // Classify bytes and track the frame phase
    scfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_q_full(q_full),
        .o_push  (push)
    );

    // Decouple classifier from builder
    scfd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Assemble the frame and hold the finished message
    scfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (q_pop),
        .o_msg   (o_msg)
    );

endmodule

// ===== rtl/core/scfd_checker.sv =====
// ----------------------------------------------------------------------------
// scfd_checker - port-level checks of the deframer
// Watches the message channel for stall behavior and payload rules.
// ----------------------------------------------------------------------------
module scfd_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [scfd_pkg::ID_W-1:0]  i_can_id,
    input logic [scfd_pkg::LEN_W-1:0] i_len,
    input scfd_pkg::t_byte          i_b3,
    input scfd_pkg::t_byte          i_b7
);
    import scfd_pkg::*;

    // A stalled message keeps its valid, id and length
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_can_id) && $stable(i_len))
        else $error("stalled message changed");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_len <= MAX_PAYLOAD)
        else $error("message length above eight");

    a_pad3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_len <= 4'd3) |-> i_b3 == '0)
        else $error("unused byte 3 not zero");

    a_pad7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_len <= 4'd7) |-> i_b7 == '0)
        else $error("unused byte 7 not zero");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("message valid right after reset");

endmodule

bind serial_to_can_frame_deframer scfd_checker u_scfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_msg.valid),
    .i_out_ready (o_msg.ready),
    .i_can_id    (o_msg.can_id),
    .i_len       (o_msg.payload_length),
    .i_b3        (o_msg.payload_b3),
    .i_b7        (o_msg.payload_b7)
);
